/* hdl/daot_pkg.sv */
// Shared types and constants of the outbox tracker: commands, result codes,
// table entry layout and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package daot_pkg;

	localparam int unsigned SIZE_BITS     = 24;
	localparam int unsigned ID_BITS       = 64;
	localparam int unsigned STATUS_BITS   = 3;
	localparam int unsigned OUT_CNT_BITS  = 6;
	localparam logic [SIZE_BITS-1:0] MAX_BYTES_RST = SIZE_BITS'(65536);

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_ACK   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_ADDED     = 3'd0,
		ST_DUP       = 3'd1,
		ST_REJECT    = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_REMOVED   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SHIFT,
		S_HEAD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   id_high;
		logic [ID_BITS-1:0]   id_low;
		logic [SIZE_BITS-1:0] size;
	} entry_t;

	typedef struct packed {
		logic [1:0]           command;
		logic [ID_BITS-1:0]   id_high;
		logic [ID_BITS-1:0]   id_low;
		logic [SIZE_BITS-1:0] put_bytes;
	} item_t;

	typedef struct packed {
		status_t                 status;
		logic                    head_valid;
		logic [ID_BITS-1:0]      head_id_high;
		logic [ID_BITS-1:0]      head_id_low;
		logic [SIZE_BITS-1:0]    head_size;
		logic [OUT_CNT_BITS-1:0] pending_count;
		logic [SIZE_BITS-1:0]    bytes_used;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;      // capture input item, restart pointer
		logic    set_st;
		status_t st_code;
		logic    scan;      // walk table looking for the id
		logic    shift;     // move entries down over the removed slot
		logic    append;    // write item at tail
		logic    clear;
		logic    ack_done;  // retire removed entry from count and bytes
		logic    head_rd;   // read slot 0 for the result
		logic    out_load;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       budget_ok;
		logic       hit;
		logic       walk_end;
		logic       full;
		logic       out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

/* hdl/dedup_ack_outbox_tracker_core.sv */
// Outbox tracker top level: stream ports, config write port, controller
// and datapath. Depends on daot_pkg, daot_ctrl, daot_datapath.
// Path from input transaction to m_tvalid: reject, clear and the unused command go
// from decode straight to the head read; put or missed ack scans every pending entry,
// one table read per entry; a duplicate put stops at the matching slot; an ack hit
// scans to the match and then compacts the entries behind it. Next input is accepted
// in the cycle after the result loads, and no earlier than m_tready frees the result register.
// Reset clears count, bytes and handshakes; budget returns to 65536, table kept.
`default_nettype none

module dedup_ack_outbox_tracker_core
	import daot_pkg::*;
#(
	parameter int unsigned ENTRIES = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [151:0] s_tdata,   // id_high, id_low, put_bytes
	input  wire logic [1:0]   s_tuser,   // command
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [183:0]      m_tdata,   // head_valid, head_id_high, head_id_low,
	                                     // head_size, pending_count, bytes_used, pad
	output logic [2:0]        m_tuser,   // status
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [23:0]  cfg_data   // max_bytes
);

	item_t    item;
	ctl_cmd_t cmd;
	dp_sts_t  sts;
	result_t  res;

	assign item.command   = s_tuser;
	assign item.id_high   = s_tdata[63:0];
	assign item.id_low    = s_tdata[127:64];
	assign item.put_bytes = s_tdata[151:128];

	assign cfg_ready = 1'b1;

	assign m_tuser = res.status;
	assign m_tdata = {1'b0, res.bytes_used, res.pending_count, res.head_size,
	                  res.head_id_low, res.head_id_high, res.head_valid};

	daot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	daot_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_q     (res)
	);

endmodule

`default_nettype wire

/* hdl/daot_ctrl.sv */
// Sequencing state machine of the outbox tracker.
// Depends on daot_pkg; drives daot_datapath through ctl_cmd_t.
`default_nettype none

module daot_ctrl
	import daot_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_sts_t  sts,
	output ctl_cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.st_code = ST_NOT_FOUND;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.cmd)
					CMD_PUT: begin
						if (sts.budget_ok) begin
							state_d = S_SCAN;
						end else begin
							cmd.set_st  = 1'b1;
							cmd.st_code = ST_REJECT;
							state_d     = S_HEAD;
						end
					end
					CMD_ACK: begin
						state_d = S_SCAN;
					end
					CMD_CLEAR: begin
						cmd.clear   = 1'b1;
						cmd.set_st  = 1'b1;
						cmd.st_code = ST_REMOVED;
						state_d     = S_HEAD;
					end
					default: begin
						cmd.set_st  = 1'b1;
						cmd.st_code = ST_NOT_FOUND;
						state_d     = S_HEAD;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					if (sts.cmd == CMD_PUT) begin
						cmd.set_st  = 1'b1;
						cmd.st_code = ST_DUP;
						state_d     = S_HEAD;
					end else begin
						state_d = S_SHIFT;
					end
				end else if (sts.walk_end) begin
					cmd.set_st = 1'b1;
					state_d    = S_HEAD;
					if (sts.cmd != CMD_PUT) begin
						cmd.st_code = ST_NOT_FOUND;
					end else if (sts.full) begin
						cmd.st_code = ST_FULL;
					end else begin
						cmd.append  = 1'b1;
						cmd.st_code = ST_ADDED;
					end
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.walk_end) begin
					cmd.ack_done = 1'b1;
					cmd.set_st   = 1'b1;
					cmd.st_code  = ST_REMOVED;
					state_d      = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.head_rd = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/daot_datapath.sv */
// Datapath of the outbox tracker: entry table memory, scan/shift pointer,
// count and byte totals, budget register and the result register.
// Depends on daot_pkg; controlled by daot_ctrl.
`default_nettype none

module daot_datapath
	import daot_pkg::*;
#(
	parameter int unsigned ENTRIES = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [SIZE_BITS-1:0] cfg_data,
	input  wire item_t                item,
	input  wire ctl_cmd_t             cmd,
	output dp_sts_t                   sts,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output result_t                   out_q
);

	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	entry_t               mem [0:ENTRIES-1];

	item_t                item_q;
	status_t              status_q;
	logic [SIZE_BITS-1:0] max_q;
	logic [CNT_W-1:0]     count_q;
	logic [SIZE_BITS-1:0] bytes_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [SIZE_BITS-1:0] hit_size_q;
	logic                 out_valid_q;

	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	entry_t               rd_data_s1;

	logic                 walking;
	logic                 issue;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 match;
	logic                 hit;
	logic [SIZE_BITS:0]   budget_sum;
	logic [31:0]          cnt_ext;

	assign walking    = cmd.scan | cmd.shift;
	assign issue      = walking && (ptr_q < count_q);
	assign rd_en      = issue | cmd.head_rd;
	assign rd_addr    = cmd.head_rd ? '0 : ptr_q[IDX_W-1:0];
	assign match      = (rd_data_s1.id_high == item_q.id_high) &&
	                    (rd_data_s1.id_low == item_q.id_low);
	assign hit        = cmd.scan && valid_s1 && match;
	assign budget_sum = {1'b0, bytes_q} + {1'b0, item_q.put_bytes};

	assign sts.cmd       = item_q.command;
	assign sts.budget_ok = (item_q.put_bytes != '0) && (budget_sum <= {1'b0, max_q});
	assign sts.hit       = hit;
	assign sts.walk_end  = (ptr_q >= count_q) && !valid_s1;
	assign sts.full      = (count_q >= CNT_W'(ENTRIES));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign cnt_ext   = 32'(count_q);

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem[count_q[IDX_W-1:0]] <= '{id_high: item_q.id_high,
			                             id_low:  item_q.id_low,
			                             size:    item_q.put_bytes};
		end else if (cmd.shift && valid_s1) begin
			mem[idx_s1 - 1'b1] <= rd_data_s1;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.set_st) begin
			status_q <= cmd.st_code;
		end
		if (issue) begin
			idx_s1 <= ptr_q[IDX_W-1:0];
		end
		if (hit) begin
			hit_size_q <= rd_data_s1.size;
		end
		if (cmd.out_load) begin
			out_q.status        <= status_q;
			out_q.head_valid    <= (count_q != '0);
			out_q.head_id_high  <= (count_q != '0) ? rd_data_s1.id_high : '0;
			out_q.head_id_low   <= (count_q != '0) ? rd_data_s1.id_low : '0;
			out_q.head_size     <= (count_q != '0) ? rd_data_s1.size : '0;
			out_q.pending_count <= cnt_ext[OUT_CNT_BITS-1:0];
			out_q.bytes_used    <= bytes_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= MAX_BYTES_RST;
			count_q     <= '0;
			bytes_q     <= '0;
			ptr_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_data;
			end
			if (cmd.clear) begin
				count_q <= '0;
				bytes_q <= '0;
			end else if (cmd.append) begin
				count_q <= count_q + 1'b1;
				bytes_q <= budget_sum[SIZE_BITS-1:0];
			end else if (cmd.ack_done) begin
				count_q <= count_q - 1'b1;
				bytes_q <= bytes_q - hit_size_q;
			end
			// a hit redirects the pointer to the slot after the match for the shift
			if (cmd.load) begin
				ptr_q    <= '0;
				valid_s1 <= 1'b0;
			end else if (hit) begin
				ptr_q    <= CNT_W'(idx_s1) + CNT_W'(1);
				valid_s1 <= 1'b0;
			end else begin
				valid_s1 <= issue;
				if (issue) begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("pending count above table depth");

	a_append_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> (!sts.full && sts.budget_ok && sts.cmd == CMD_PUT))
		else $error("append without room or budget");

	a_ack_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ack_done |-> (count_q != '0 && bytes_q >= hit_size_q))
		else $error("ack retire on empty table or byte underflow");

	a_shift_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && valid_s1) |-> (idx_s1 != '0))
		else $error("shift write below slot zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result overwritten before taken");

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for dedup_ack_outbox_tracker_core: a scoreboard class
// predicts every result from the accepted input transactions. Needs daot_pkg.
`timescale 1ns / 1ps

module tb_top
	import daot_pkg::*;
;

	localparam int ENTRIES     = 32;
	localparam int POOL        = 48;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE      = 2 * ENTRIES + 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;   // id_high, id_low, put_bytes
	logic [1:0]   s_tuser;   // command
	logic         m_tvalid;
	logic         m_tready;
	logic [183:0] m_tdata;   // head_valid, head_id_high, head_id_low, head_size,
	                         // pending_count, bytes_used, pad
	logic [2:0]   m_tuser;   // status
	logic         cfg_valid;
	logic         cfg_ready;
	logic [23:0]  cfg_data;  // max_bytes

	bit           calm;
	int           hold_left;
	logic [63:0]  pool_hi [POOL];
	logic [63:0]  pool_lo [POOL];

	dedup_ack_outbox_tracker_core #(.ENTRIES(ENTRIES)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	class outbox_scoreboard;
		entry_t      pending[$];
		logic [23:0] budget;
		logic [23:0] bytes_pending;
		result_t     awaited_results[$];
		int          mismatches;
		int          checked;

		function new();
			budget = MAX_BYTES_RST;
			bytes_pending = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_budget(logic [23:0] value);
			budget = value;
		endfunction

		function int find_id(logic [63:0] hi, logic [63:0] lo);
			foreach (pending[i])
				if (pending[i].id_high == hi && pending[i].id_low == lo)
					return i;
			return -1;
		endfunction

		function int outstanding();
			return awaited_results.size();
		endfunction

		function void note_item(logic [1:0] cmd, logic [63:0] hi, logic [63:0] lo,
				logic [23:0] nbytes);
			result_t r;
			entry_t  e;
			int      slot;
			r = '0;
			r.status = ST_NOT_FOUND;
			if (cmd == CMD_PUT) begin
				// budget checks come before the duplicate search
				if (nbytes == 0 || nbytes > budget || bytes_pending > budget - nbytes)
					r.status = ST_REJECT;
				else if (find_id(hi, lo) >= 0)
					r.status = ST_DUP;
				else if (pending.size() >= ENTRIES)
					r.status = ST_FULL;
				else begin
					e.id_high = hi;
					e.id_low = lo;
					e.size = nbytes;
					pending.push_back(e);
					bytes_pending = bytes_pending + nbytes;
					r.status = ST_ADDED;
				end
			end else if (cmd == CMD_ACK) begin
				slot = find_id(hi, lo);
				if (slot >= 0) begin
					bytes_pending = bytes_pending - pending[slot].size;
					pending.delete(slot);
					r.status = ST_REMOVED;
				end
			end else if (cmd == CMD_CLEAR) begin
				pending.delete();
				bytes_pending = '0;
				r.status = ST_REMOVED;
			end
			if (pending.size() > 0) begin
				r.head_valid = 1'b1;
				r.head_id_high = pending[0].id_high;
				r.head_id_low = pending[0].id_low;
				r.head_size = pending[0].size;
			end
			r.pending_count = 6'(pending.size());
			r.bytes_used = bytes_pending;
			awaited_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t e;
			checked++;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result #%0d arrived with nothing outstanding", $time, checked);
				return;
			end
			e = awaited_results.pop_front();
			if (got.status !== e.status || got.head_valid !== e.head_valid ||
					got.head_id_high !== e.head_id_high || got.head_id_low !== e.head_id_low ||
					got.head_size !== e.head_size || got.pending_count !== e.pending_count ||
					got.bytes_used !== e.bytes_used) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result #%0d mismatch", $time, checked);
					$display("  exp status=%0d hv=%0b head=%h_%h size=%0d count=%0d bytes=%0d",
						e.status, e.head_valid, e.head_id_high, e.head_id_low, e.head_size,
						e.pending_count, e.bytes_used);
					$display("  got status=%0d hv=%0b head=%h_%h size=%0d count=%0d bytes=%0d",
						got.status, got.head_valid, got.head_id_high, got.head_id_low,
						got.head_size, got.pending_count, got.bytes_used);
				end
			end
		endfunction
	endclass

	outbox_scoreboard sb;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tuser);
			got.head_valid = m_tdata[0];
			got.head_id_high = m_tdata[64:1];
			got.head_id_low = m_tdata[128:65];
			got.head_size = m_tdata[152:129];
			got.pending_count = m_tdata[158:153];
			got.bytes_used = m_tdata[182:159];
			sb.check_result(got);
		end
	end

	// receiver: random backpressure, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else
				m_tready = calm || ($urandom_range(99) >= 24);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_item(input logic [1:0] cmd, input logic [63:0] hi,
			input logic [63:0] lo, input logic [23:0] nbytes);
		if (!calm && $urandom_range(99) < 24) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {nbytes, lo, hi};
		do @(posedge clk); while (!s_tready);
		sb.note_item(cmd, hi, lo, nbytes);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_budget(input logic [23:0] value);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_budget(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic pick_id(input logic [1:0] cmd, output logic [63:0] hi, output logic [63:0] lo);
		int k;
		if (cmd == CMD_ACK && sb.pending.size() > 0 && $urandom_range(99) < 70) begin
			k = $urandom_range(sb.pending.size() - 1);
			hi = sb.pending[k].id_high;
			lo = sb.pending[k].id_low;
		end else if ($urandom_range(99) < 80) begin
			k = $urandom_range(POOL - 1);
			hi = pool_hi[k];
			lo = pool_lo[k];
		end else begin
			hi = {$urandom, $urandom};
			lo = {$urandom, $urandom};
		end
	endtask

	function automatic logic [23:0] pick_size(input int size_cap);
		int roll;
		roll = $urandom_range(99);
		if (roll < 4)
			return '0;
		if (roll < 8)
			return 24'($urandom);
		if (roll < 16)  // exactly the room left, or one byte too many
			return (sb.budget > sb.bytes_pending) ?
				sb.budget - sb.bytes_pending + 24'($urandom_range(1)) : 24'd1;
		return 24'($urandom_range(1, size_cap));
	endfunction

	task automatic random_phase(input int count, input int size_cap, input int put_pct,
			input int ack_pct);
		logic [1:0]  cmd;
		logic [63:0] hi;
		logic [63:0] lo;
		int          roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < put_pct)
				cmd = CMD_PUT;
			else if (roll < put_pct + ack_pct)
				cmd = CMD_ACK;
			else if (roll < 99)
				cmd = CMD_CLEAR;
			else
				cmd = CMD_UNUSED;
			pick_id(cmd, hi, lo);
			send_item(cmd, hi, lo, pick_size(size_cap));
		end
	endtask

	initial begin
		logic [23:0] b;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		calm = 1'b0;
		hold_left = 0;
		foreach (pool_hi[i]) begin
			pool_hi[i] = {$urandom, $urandom};
			pool_lo[i] = {$urandom, $urandom};
		end
		pool_hi[0] = '1;
		pool_lo[0] = '1;
		pool_hi[1] = '0;
		pool_lo[1] = '0;
		pool_hi[2] = pool_hi[3];  // ids that differ in one half only
		pool_lo[4] = pool_lo[5];
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset budget of 65536
		send_item(CMD_ACK, pool_hi[0], pool_lo[0], 24'd0);
		send_item(CMD_PUT, pool_hi[6], pool_lo[6], 24'd0);
		send_item(CMD_PUT, pool_hi[6], pool_lo[6], 24'd65537);
		send_item(CMD_PUT, pool_hi[0], pool_lo[0], 24'd65536);
		send_item(CMD_PUT, pool_hi[6], pool_lo[6], 24'd1);
		send_item(CMD_PUT, pool_hi[0], pool_lo[0], 24'd1);  // over budget wins over dup
		send_item(CMD_UNUSED, '1, '1, '1);
		send_item(CMD_ACK, pool_hi[0], pool_lo[0], '1);
		send_item(CMD_PUT, pool_hi[1], pool_lo[1], 24'd1);
		send_item(CMD_PUT, pool_hi[1], pool_lo[1], 24'd1);
		send_item(CMD_PUT, pool_hi[2], pool_lo[2], 24'd100);
		send_item(CMD_ACK, pool_hi[3], pool_lo[3], 24'd0);
		send_item(CMD_PUT, pool_hi[3], pool_lo[3], 24'd200);
		send_item(CMD_ACK, pool_hi[2], pool_lo[2], 24'd0);  // middle slot
		send_item(CMD_CLEAR, pool_hi[7], pool_lo[7], 24'd9);
		send_item(CMD_CLEAR, '0, '0, '0);
		send_item(CMD_PUT, pool_hi[1], pool_lo[1], 24'd5);
		send_item(CMD_PUT, pool_hi[4], pool_lo[4], 24'd7);
		send_item(CMD_ACK, pool_hi[5], pool_lo[5], 24'd0);

		write_budget(24'd0);
		random_phase(60, 1000, 60, 38);

		write_budget(24'hFFFFFF);
		calm = 1'b1;
		random_phase(400, 1 << 19, 65, 33);
		calm = 1'b0;

		// receiver stalls while items keep coming
		hold_left = 400;
		random_phase(60, 1 << 19, 65, 33);

		// below the bytes already pending
		write_budget(24'd3000);
		random_phase(300, 200, 55, 43);

		write_budget(MAX_BYTES_RST);
		random_phase(400, 3000, 65, 33);

		b = 24'($urandom_range(1, 24'hFFFFFF));
		write_budget(b);
		random_phase(300, (b >> 4) + 1, 62, 36);

		write_budget(24'd1);
		random_phase(100, 2, 60, 38);

		write_budget(24'hFFFFFF);
		random_phase(230, 100, 70, 28);

		wait_drained();
		repeat (SETTLE) @(negedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
